// ===== src/bzf_pkg.sv =====
// ----------------------------------------------------------------------------
// bzf_pkg: shared types and constants of the cubic Bezier flattener
// Fixed-point formats, item structs and the control bundles passed between the
// step sequencer, the weight pipeline, the lanes and the merge stage.
// ----------------------------------------------------------------------------
`default_nettype none

package bzf_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int COORD_BITS   = 16;
  localparam int MAX_SEGMENTS = 64;
  localparam int NUM_PTS      = 4;
  localparam int CNT_W        = 7;
  localparam int COLOR_W      = 32;

  // t and u are Q1.F, the middle weights need one more integer bit.
  localparam int T_W    = FRAC_BITS + 1;
  localparam int W_W    = FRAC_BITS + 2;
  localparam int PROD_W = COORD_BITS + W_W + 1;
  localparam int SUM_W  = PROD_W + 2;
  localparam int QW     = SUM_W - FRAC_BITS;
  localparam int REM_W  = $clog2(MAX_SEGMENTS);
  localparam int DCNT_W = $clog2(T_W);

  localparam logic [T_W-1:0]          ONE_FX  = T_W'(64'd1 << FRAC_BITS);
  localparam logic [CNT_W-1:0]        SEG_MIN = CNT_W'(2);
  localparam logic [CNT_W-1:0]        SEG_MAX = CNT_W'(MAX_SEGMENTS);
  localparam logic signed [SUM_W-1:0] BIAS    = SUM_W'((64'd1 << FRAC_BITS) - 64'd1);
  localparam logic signed [QW-1:0]    SAT_MAX = QW'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam logic signed [QW-1:0]    SAT_MIN = QW'(-(64'sd1 <<< (COORD_BITS - 1)));

  typedef struct packed {
    logic signed [COORD_BITS-1:0] p0_x;
    logic signed [COORD_BITS-1:0] p0_y;
    logic signed [COORD_BITS-1:0] p1_x;
    logic signed [COORD_BITS-1:0] p1_y;
    logic signed [COORD_BITS-1:0] p2_x;
    logic signed [COORD_BITS-1:0] p2_y;
    logic signed [COORD_BITS-1:0] p3_x;
    logic signed [COORD_BITS-1:0] p3_y;
    logic [CNT_W-1:0]             segment_count;
    logic [COLOR_W-1:0]           draw_color;
  } curve_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
    logic [COLOR_W-1:0]           seg_color;
    logic                         last_segment;
  } seg_t;

  typedef struct packed {
    logic valid;
    logic last;
  } ctl_t;

  typedef struct packed {
    ctl_t           ctl;
    logic [T_W-1:0] t;
  } step_t;

  typedef struct packed {
    ctl_t                         ctl;
    logic [NUM_PTS-1:0][W_W-1:0]  w;
  } wgt_t;

endpackage

`default_nettype wire

// ===== src/bzf_if.sv =====
// ----------------------------------------------------------------------------
// bzf_if: valid/ready channels of the cubic Bezier flattener
// One channel carries curves in, the other carries line segments out.
// ----------------------------------------------------------------------------
`default_nettype none

interface bzf_curve_if;
  logic            valid;
  logic            ready;
  bzf_pkg::curve_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bzf_seg_if;
  logic          valid;
  logic          ready;
  bzf_pkg::seg_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== src/bzf_seq.sv =====
// ----------------------------------------------------------------------------
// bzf_seq: curve intake and step sequencer
// Clamps the segment count, finds 2^F / n with a serial restoring divider and
// then issues t = floor(i * 2^F / n) for i = 1..n, one step per cycle while adv is high.
// ----------------------------------------------------------------------------
`default_nettype none

module bzf_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  bzf_curve_if.sink            in_curve,
  input  logic                 adv,
  input  logic                 pipe_busy,
  output bzf_pkg::step_t       step,
  output logic                 load,
  output bzf_pkg::curve_t      pend,
  output bzf_pkg::curve_t      act
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_DIV  = 4'b0010,
    ST_HOLD = 4'b0100,
    ST_STEP = 4'b1000
  } seq_state_t;

  seq_state_t state_r, state_nxt;

  bzf_pkg::curve_t                pend_r, pend_nxt;
  bzf_pkg::curve_t                act_r, act_nxt;
  logic [bzf_pkg::CNT_W-1:0]      n_r, n_nxt;
  logic [bzf_pkg::CNT_W-1:0]      cnt_in;
  logic [bzf_pkg::T_W-1:0]        dq_r, dq_nxt;
  logic [bzf_pkg::REM_W-1:0]      rem_r, rem_nxt;
  logic [bzf_pkg::DCNT_W-1:0]     dcnt_r, dcnt_nxt;
  logic [bzf_pkg::T_W-1:0]        t_r, t_nxt;
  logic [bzf_pkg::REM_W-1:0]      racc_r, racc_nxt;
  logic [bzf_pkg::CNT_W-1:0]      i_r, i_nxt;
  logic                           s0v_r, s0v_nxt;
  logic                           s0l_r, s0l_nxt;

  logic [bzf_pkg::REM_W:0]        rem_sh, div_diff;
  logic                           div_ge;
  logic [bzf_pkg::REM_W:0]        rsum, step_diff;
  logic                           step_ge;

  assign in_curve.ready = (state_r == ST_IDLE);
  assign step.ctl.valid = s0v_r;
  assign step.ctl.last  = s0l_r;
  assign step.t         = t_r;
  assign pend           = pend_r;
  assign act            = act_r;

  assign cnt_in = in_curve.data.segment_count;

  always_comb begin
    state_nxt = state_r;
    pend_nxt  = pend_r;
    act_nxt   = act_r;
    n_nxt     = n_r;
    dq_nxt    = dq_r;
    rem_nxt   = rem_r;
    dcnt_nxt  = dcnt_r;
    t_nxt     = t_r;
    racc_nxt  = racc_r;
    i_nxt     = i_r;
    s0v_nxt   = s0v_r;
    s0l_nxt   = s0l_r;
    load      = 1'b0;

    rem_sh    = {rem_r, dq_r[bzf_pkg::T_W-1]};
    div_ge    = (rem_sh >= n_r);
    div_diff  = rem_sh - n_r;
    // Remainder of i * 2^F / n is carried along with the quotient.
    rsum      = {1'b0, racc_r} + {1'b0, rem_r};
    step_ge   = (rsum >= n_r);
    step_diff = rsum - n_r;

    if (adv) begin
      s0v_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_curve.valid) begin
          pend_nxt = in_curve.data;
          if (cnt_in < bzf_pkg::SEG_MIN) begin
            n_nxt = bzf_pkg::SEG_MIN;
          end else if (cnt_in > bzf_pkg::SEG_MAX) begin
            n_nxt = bzf_pkg::SEG_MAX;
          end else begin
            n_nxt = cnt_in;
          end
          dq_nxt    = bzf_pkg::ONE_FX;
          rem_nxt   = '0;
          dcnt_nxt  = bzf_pkg::DCNT_W'(bzf_pkg::T_W - 1);
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt  = div_ge ? div_diff[bzf_pkg::REM_W-1:0] : rem_sh[bzf_pkg::REM_W-1:0];
        dq_nxt   = {dq_r[bzf_pkg::T_W-2:0], div_ge};
        dcnt_nxt = dcnt_r - bzf_pkg::DCNT_W'(1);
        if (dcnt_r == '0) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        // The lanes read the active curve, so the previous curve must drain first.
        if (!pipe_busy && !s0v_r) begin
          load      = 1'b1;
          act_nxt   = pend_r;
          t_nxt     = '0;
          racc_nxt  = '0;
          i_nxt     = bzf_pkg::CNT_W'(1);
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: begin
        if (adv) begin
          t_nxt    = t_r + dq_r + bzf_pkg::T_W'(step_ge);
          racc_nxt = step_ge ? step_diff[bzf_pkg::REM_W-1:0] : rsum[bzf_pkg::REM_W-1:0];
          i_nxt    = i_r + bzf_pkg::CNT_W'(1);
          s0v_nxt  = 1'b1;
          s0l_nxt  = (i_r == n_r);
          if (i_r == n_r) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      s0v_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      s0v_r   <= s0v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    act_r  <= act_nxt;
    n_r    <= n_nxt;
    dq_r   <= dq_nxt;
    rem_r  <= rem_nxt;
    dcnt_r <= dcnt_nxt;
    t_r    <= t_nxt;
    racc_r <= racc_nxt;
    i_r    <= i_nxt;
    s0l_r  <= s0l_nxt;
  end

  a_last_t_is_one: assert property (@(posedge clk) disable iff (!rst_n)
    s0v_r && s0l_r |-> t_r == bzf_pkg::ONE_FX)
    else $error("final step of a curve does not land on t = 1.0");

  a_racc_below_n: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_STEP |-> {1'b0, racc_r} < n_r)
    else $error("step remainder is not below the segment count");

  a_quot_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_STEP |-> dq_r != '0)
    else $error("step size from the divider is zero");

endmodule

`default_nettype wire

// ===== src/bzf_weight.sv =====
// ----------------------------------------------------------------------------
// bzf_weight: Bernstein weight pipeline
// Two registered multiply stages turn t into the four cubic weights
// (1-t)^3, 3(1-t)^2 t, 3(1-t) t^2 and t^3, each truncated to F fraction bits.
// ----------------------------------------------------------------------------
`default_nettype none

module bzf_weight (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  bzf_pkg::step_t step,
  output bzf_pkg::wgt_t  wgt,
  output logic           busy
);

  localparam int F = bzf_pkg::FRAC_BITS;

  bzf_pkg::ctl_t                 s1_ctl_r;
  logic [bzf_pkg::T_W-1:0]       u1_r, t1_r, uu_r, tt_r;
  bzf_pkg::wgt_t                 wgt_r;

  logic [bzf_pkg::T_W-1:0]       u;
  logic [2*bzf_pkg::T_W-1:0]     uu_full, tt_full, w0_full, w3_full;
  logic [bzf_pkg::W_W-1:0]       m1, m2;
  logic [bzf_pkg::W_W+bzf_pkg::T_W-1:0] w1_full, w2_full;

  assign u       = bzf_pkg::ONE_FX - step.t;
  assign uu_full = u * u;
  assign tt_full = step.t * step.t;

  assign w0_full = uu_r * u1_r;
  assign w3_full = tt_r * t1_r;
  assign m1      = {1'b0, uu_r} + {uu_r, 1'b0};
  assign m2      = {1'b0, tt_r} + {tt_r, 1'b0};
  assign w1_full = m1 * t1_r;
  assign w2_full = m2 * u1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r.valid  <= 1'b0;
      wgt_r.ctl.valid <= 1'b0;
    end else if (adv) begin
      s1_ctl_r   <= step.ctl;
      u1_r       <= u;
      t1_r       <= step.t;
      uu_r       <= uu_full[2*F:F];
      tt_r       <= tt_full[2*F:F];
      wgt_r.ctl  <= s1_ctl_r;
      wgt_r.w[0] <= {1'b0, w0_full[2*F:F]};
      wgt_r.w[1] <= w1_full[2*F+1:F];
      wgt_r.w[2] <= w2_full[2*F+1:F];
      wgt_r.w[3] <= {1'b0, w3_full[2*F:F]};
    end
  end

  assign wgt  = wgt_r;
  assign busy = s1_ctl_r.valid | wgt_r.ctl.valid;

endmodule

`default_nettype wire

// ===== src/bzf_lane.sv =====
// ----------------------------------------------------------------------------
// bzf_lane: one control-point lane
// Scales one control point by its weight, x and y side by side.
// ----------------------------------------------------------------------------
`default_nettype none

module bzf_lane (
  input  logic                                clk,
  input  logic                                adv,
  input  logic [bzf_pkg::W_W-1:0]             w,
  input  logic signed [bzf_pkg::COORD_BITS-1:0] px,
  input  logic signed [bzf_pkg::COORD_BITS-1:0] py,
  output logic signed [bzf_pkg::PROD_W-1:0]   prod_x,
  output logic signed [bzf_pkg::PROD_W-1:0]   prod_y
);

  logic signed [bzf_pkg::W_W:0]      ws;
  logic signed [bzf_pkg::PROD_W-1:0] prod_x_r, prod_y_r;

  assign ws = signed'({1'b0, w});

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_x_r <= ws * px;
      prod_y_r <= ws * py;
    end
  end

  assign prod_x = prod_x_r;
  assign prod_y = prod_y_r;

endmodule

`default_nettype wire

// ===== src/bzf_merge.sv =====
// ----------------------------------------------------------------------------
// bzf_merge: lane merge and segment output register
// Sums the four lane products per axis, truncates toward zero, saturates and
// pairs each curve point with the previous one to form a segment.
// ----------------------------------------------------------------------------
`default_nettype none

module bzf_merge (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  bzf_pkg::ctl_t                         ctl,
  input  logic signed [bzf_pkg::PROD_W-1:0]     prod_x [bzf_pkg::NUM_PTS],
  input  logic signed [bzf_pkg::PROD_W-1:0]     prod_y [bzf_pkg::NUM_PTS],
  input  logic                                  load,
  input  logic signed [bzf_pkg::COORD_BITS-1:0] p0_x,
  input  logic signed [bzf_pkg::COORD_BITS-1:0] p0_y,
  input  logic [bzf_pkg::COLOR_W-1:0]           color,
  bzf_seg_if.source                             out_seg,
  output logic                                  adv,
  output logic                                  busy
);

  localparam int F = bzf_pkg::FRAC_BITS;

  function automatic logic signed [bzf_pkg::COORD_BITS-1:0] to_coord(
    input logic signed [bzf_pkg::SUM_W-1:0] s
  );
    logic signed [bzf_pkg::SUM_W-1:0] adj;
    logic signed [bzf_pkg::QW-1:0]    q;
    adj = s;
    // A negative sum gets a bias so the shift rounds toward zero.
    if (s[bzf_pkg::SUM_W-1]) begin
      adj = s + bzf_pkg::BIAS;
    end
    q = adj[bzf_pkg::SUM_W-1:F];
    if (q > bzf_pkg::SAT_MAX) begin
      q = bzf_pkg::SAT_MAX;
    end else if (q < bzf_pkg::SAT_MIN) begin
      q = bzf_pkg::SAT_MIN;
    end
    return q[bzf_pkg::COORD_BITS-1:0];
  endfunction

  bzf_pkg::ctl_t                        s3_ctl_r, s4_ctl_r;
  logic signed [bzf_pkg::SUM_W-1:0]     sum_x, sum_y, s4_x_r, s4_y_r;
  logic signed [bzf_pkg::COORD_BITS-1:0] pt_x, pt_y, prev_x_r, prev_y_r;
  logic                                 out_v_r;
  bzf_pkg::seg_t                        out_r;

  assign adv = !out_v_r || out_seg.ready;

  assign sum_x = bzf_pkg::SUM_W'(prod_x[0]) + bzf_pkg::SUM_W'(prod_x[1])
               + bzf_pkg::SUM_W'(prod_x[2]) + bzf_pkg::SUM_W'(prod_x[3]);
  assign sum_y = bzf_pkg::SUM_W'(prod_y[0]) + bzf_pkg::SUM_W'(prod_y[1])
               + bzf_pkg::SUM_W'(prod_y[2]) + bzf_pkg::SUM_W'(prod_y[3]);

  assign pt_x = to_coord(s4_x_r);
  assign pt_y = to_coord(s4_y_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_ctl_r.valid <= 1'b0;
      s4_ctl_r.valid <= 1'b0;
      out_v_r        <= 1'b0;
    end else if (adv) begin
      s3_ctl_r <= ctl;
      s4_ctl_r <= s3_ctl_r;
      out_v_r  <= s4_ctl_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_x_r <= sum_x;
      s4_y_r <= sum_y;
      if (s4_ctl_r.valid) begin
        out_r.start_x      <= prev_x_r;
        out_r.start_y      <= prev_y_r;
        out_r.end_x        <= pt_x;
        out_r.end_y        <= pt_y;
        out_r.seg_color    <= color;
        out_r.last_segment <= s4_ctl_r.last;
        prev_x_r           <= pt_x;
        prev_y_r           <= pt_y;
      end
    end
    // A new curve starts only once the stages above are empty.
    if (load) begin
      prev_x_r <= p0_x;
      prev_y_r <= p0_y;
    end
  end

  assign out_seg.valid = out_v_r;
  assign out_seg.data  = out_r;
  assign busy          = s3_ctl_r.valid | s4_ctl_r.valid;

endmodule

`default_nettype wire

// ===== src/cubic_bezier_flattener_core.sv =====
// ----------------------------------------------------------------------------
// cubic_bezier_flattener_core: cubic Bezier curve to line segments
// Evaluates the curve at n evenly spaced t and emits one segment per step.
//
//   Channel    Dir   Handshake      Item
//   in_curve   in    valid/ready    four control points, segment count, color
//   out_seg    out   valid/ready    start/end point, color, last flag
//
// An accepted curve goes through the serial divider, then waits until the previous
// curve has drained and is loaded; its n steps, n = 2..64, then issue one step per
// cycle unless the output stalls. A step passes the weight stages, the lane products,
// sum and output registers; the next curve is accepted and divided as the last drains.
// Reset is synchronous and active low; it clears all valid flags.
// A stalled output freezes the whole pipeline and the step issue.
// ----------------------------------------------------------------------------
`default_nettype none

module cubic_bezier_flattener_core (
  input  logic      clk,
  input  logic      rst_n,
  bzf_curve_if.sink in_curve,
  bzf_seg_if.source out_seg
);

  logic                                   adv;
  logic                                   load;
  logic                                   wgt_busy, mrg_busy;
  bzf_pkg::step_t                         step;
  bzf_pkg::wgt_t                          wgt;
  bzf_pkg::curve_t                        pend, act;
  logic signed [bzf_pkg::COORD_BITS-1:0]  px [bzf_pkg::NUM_PTS];
  logic signed [bzf_pkg::COORD_BITS-1:0]  py [bzf_pkg::NUM_PTS];
  logic signed [bzf_pkg::PROD_W-1:0]      prod_x [bzf_pkg::NUM_PTS];
  logic signed [bzf_pkg::PROD_W-1:0]      prod_y [bzf_pkg::NUM_PTS];

  assign px[0] = act.p0_x;
  assign py[0] = act.p0_y;
  assign px[1] = act.p1_x;
  assign py[1] = act.p1_y;
  assign px[2] = act.p2_x;
  assign py[2] = act.p2_y;
  assign px[3] = act.p3_x;
  assign py[3] = act.p3_y;

  bzf_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_curve  (in_curve),
    .adv       (adv),
    .pipe_busy (wgt_busy | mrg_busy),
    .step      (step),
    .load      (load),
    .pend      (pend),
    .act       (act)
  );

  bzf_weight u_weight (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .step  (step),
    .wgt   (wgt),
    .busy  (wgt_busy)
  );

  for (genvar k = 0; k < bzf_pkg::NUM_PTS; k++) begin : g_lane
    bzf_lane u_lane (
      .clk    (clk),
      .adv    (adv),
      .w      (wgt.w[k]),
      .px     (px[k]),
      .py     (py[k]),
      .prod_x (prod_x[k]),
      .prod_y (prod_y[k])
    );
  end

  bzf_merge u_merge (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (wgt.ctl),
    .prod_x  (prod_x),
    .prod_y  (prod_y),
    .load    (load),
    .p0_x    (pend.p0_x),
    .p0_y    (pend.p0_y),
    .color   (act.draw_color),
    .out_seg (out_seg),
    .adv     (adv),
    .busy    (mrg_busy)
  );

endmodule

`default_nettype wire
